// File: hdl/phtt_pkg.sv
// shared constants, types and item codes for the phase-to-point triangulator
package phtt_pkg;

  localparam int COORD_BITS      = 12;
  localparam int PHASE_FRAC_BITS = 8;

  localparam int CMD_W     = 1;
  localparam int IDX_W     = 5;
  localparam int COEF_W    = 32;
  localparam int PIX_W     = 12;
  localparam int PHASE_W   = 20;
  localparam int OUT_W     = 32;

  localparam int TABLE_DEPTH = 24;
  localparam int TERMS       = 6;
  localparam int ROWS        = 4;
  localparam int HALF_TERMS  = TERMS / 2;
  localparam int LANES       = ROWS - 1;

  localparam int PROD_W = COEF_W + PHASE_W + 1;
  localparam int AW     = PROD_W + 1;
  localparam int PRW    = AW + COORD_BITS + 1;
  localparam int HW     = PRW + 2;

  localparam int FRAC_SHIFT = 16;
  localparam int DIV_STEPS  = OUT_W;
  localparam int REM_W      = HW + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    K_LOAD,
    K_MASKED,
    K_PIXEL
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [IDX_W-1:0]        idx;
    logic [COEF_W-1:0]       value;
    logic [COORD_BITS-1:0]   col;
    logic [COORD_BITS-1:0]   row;
    logic [PHASE_W-1:0]      phase;
  } job_t;

  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic [ROWS-1:0][HW-1:0] h;
  } hom_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] q;
    logic                 neg;
    logic                 big;
  } lane_t;

endpackage

// File: hdl/phtt_if.sv
// valid/ready channel interfaces for pixel items and point items
interface phtt_in_if;
  import phtt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [IDX_W-1:0]          coef_index;
  logic signed [COEF_W-1:0]  coef_value;
  logic [PIX_W-1:0]          pixel_col;
  logic [PIX_W-1:0]          pixel_row;
  logic [PHASE_W-1:0]        phase;
  logic                      mask_bit;

  modport source (output valid, cmd, coef_index, coef_value, pixel_col, pixel_row, phase,
                  mask_bit, input ready);
  modport sink (input valid, cmd, coef_index, coef_value, pixel_col, pixel_row, phase,
                mask_bit, output ready);
endinterface

interface phtt_out_if;
  import phtt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     point_valid;
  logic signed [OUT_W-1:0]  coord_x;
  logic signed [OUT_W-1:0]  coord_y;
  logic signed [OUT_W-1:0]  coord_z;
  logic                     saturated;

  modport source (output valid, point_valid, coord_x, coord_y, coord_z, saturated,
                  input ready);
  modport sink (input valid, point_valid, coord_x, coord_y, coord_z, saturated,
                output ready);
endinterface

// File: hdl/phase_to_point_triangulator_top.sv
// top level of the phase-to-point triangulator
//
// in_ch carries load items (cmd 0: coefficient index and value) and pixel
// items (cmd 1: column, row, phase, mask). loads past the table are dropped.
// out_ch carries one point item per pixel item and nothing for loads.
// items enter a four-deep queue; the back pipeline pops one item per cycle
// while out_ch does not stall, writes loads into the coefficient table in
// item order and runs pixels through four stages of row sums, a magnitude
// stage, a range check and a 32-stage restoring divider, one quotient bit
// per stage for x, y and z. throughput is one item per cycle while out_ch
// does not stall. when the receiver holds ready low against a valid point
// item, the whole back pipeline holds and the queue fills; in_ch ready
// falls once the queue is full.
// reset empties the queue and the pipeline; the coefficient table keeps no
// reset value and must be loaded before pixels that use it.
module phase_to_point_triangulator_top (
  input  logic        clk,
  input  logic        rst,
  phtt_in_if.sink     in_ch,
  phtt_out_if.source  out_ch
);
  import phtt_pkg::*;

  job_t  push_job;
  logic  push_valid;
  logic  push_ready;
  job_t  head;
  logic  head_valid;
  logic  pop;
  logic  en;
  hom_t  hom;

  phtt_front u_front (
    .in_ch     (in_ch),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  phtt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  phtt_hom u_hom (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .hom        (hom)
  );

  phtt_div u_div (
    .clk    (clk),
    .rst    (rst),
    .hom    (hom),
    .en     (en),
    .out_ch (out_ch)
  );
endmodule

// File: hdl/phtt_front.sv
// input side: classifies items and drops loads aimed past the table
module phtt_front (
  phtt_in_if.sink         in_ch,
  output phtt_pkg::job_t  job,
  output logic            job_valid,
  input  logic            job_ready
);
  import phtt_pkg::*;

  logic is_load;

  assign is_load = (in_ch.cmd == CMD_LOAD);
  assign in_ch.ready = job_ready;
  assign job_valid = in_ch.valid &&
                     !(is_load && (in_ch.coef_index >= IDX_W'(TABLE_DEPTH)));

  always_comb begin
    if (is_load) begin
      job.kind = K_LOAD;
    end else if (in_ch.mask_bit) begin
      job.kind = K_PIXEL;
    end else begin
      job.kind = K_MASKED;
    end
    job.idx   = in_ch.coef_index;
    job.value = in_ch.coef_value;
    job.col   = COORD_BITS'(in_ch.pixel_col);
    job.row   = COORD_BITS'(in_ch.pixel_row);
    job.phase = in_ch.phase;
  end
endmodule

// File: hdl/phtt_queue.sv
// short item queue between the front and the back
module phtt_queue (
  input  logic            clk,
  input  logic            rst,
  input  phtt_pkg::job_t  push_job,
  input  logic            push_valid,
  output logic            push_ready,
  output phtt_pkg::job_t  head,
  output logic            head_valid,
  input  logic            pop
);
  import phtt_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// File: hdl/phtt_hom.sv
// coefficient table and the pipelined homogeneous row sums
module phtt_hom (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  phtt_pkg::job_t  head,
  input  logic            head_valid,
  output logic            pop,
  output phtt_pkg::hom_t  hom
);
  import phtt_pkg::*;

  logic [COEF_W-1:0]        coef_table [TABLE_DEPTH];

  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] m_d [ROWS][HALF_TERMS];

  logic                     v1, v2, v3, v4;
  kind_t                    k1, k2, k3, k4;
  logic [COORD_BITS-1:0]    col1, row1, col2, row2;
  logic [COEF_W-1:0]        c1 [ROWS][HALF_TERMS];
  logic signed [PROD_W-1:0] m1 [ROWS][HALF_TERMS];
  logic signed [AW-1:0]     a2 [ROWS][HALF_TERMS];
  logic signed [AW-1:0]     a0_3 [ROWS];
  logic signed [PRW-1:0]    pc3 [ROWS];
  logic signed [PRW-1:0]    pr3 [ROWS];
  logic signed [HW-1:0]     h4 [ROWS];
  logic signed [PRW-1:0]    colx, rowx;

  assign pop = en && head_valid;
  assign px  = PROD_W'($signed({1'b0, head.phase}));

  always_comb begin
    for (int h = 0; h < ROWS; h++) begin
      for (int t = 0; t < HALF_TERMS; t++) begin
        m_d[h][t] = PROD_W'($signed(coef_table[h*TERMS+t+HALF_TERMS])) * px;
      end
    end
  end

  // loads take effect in item order, here at the head of the back
  always_ff @(posedge clk) begin
    if (pop && (head.kind == K_LOAD)) begin
      coef_table[head.idx] <= head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= head_valid && (head.kind != K_LOAD);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign colx = PRW'($signed({1'b0, col2}));
  assign rowx = PRW'($signed({1'b0, row2}));

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= head.kind;
      col1 <= head.col;
      row1 <= head.row;
      k2   <= k1;
      col2 <= col1;
      row2 <= row1;
      k3   <= k2;
      k4   <= k3;
      for (int h = 0; h < ROWS; h++) begin
        for (int t = 0; t < HALF_TERMS; t++) begin
          c1[h][t] <= coef_table[h*TERMS+t];
          m1[h][t] <= m_d[h][t];
          a2[h][t] <= (AW'($signed(c1[h][t])) <<< PHASE_FRAC_BITS) - AW'(m1[h][t]);
        end
        a0_3[h] <= a2[h][0];
        pc3[h]  <= PRW'(a2[h][1]) * colx;
        pr3[h]  <= PRW'(a2[h][2]) * rowx;
        h4[h]   <= HW'(a0_3[h]) - HW'(pc3[h]) - HW'(pr3[h]);
      end
    end
  end

  always_comb begin
    hom.valid = v4;
    hom.kind  = k4;
    for (int h = 0; h < ROWS; h++) begin
      hom.h[h] = h4[h];
    end
  end
endmodule

// File: hdl/phtt_div.sv
// pipelined restoring dividers for x/w, y/w, z/w, saturation and output register
module phtt_div (
  input  logic            clk,
  input  logic            rst,
  input  phtt_pkg::hom_t  hom,
  output logic            en,
  phtt_out_if.source      out_ch
);
  import phtt_pkg::*;

  logic                 d0_valid, d0_pt;
  logic [HW-1:0]        d0_md;
  logic [HW-1:0]        d0_mn [LANES];
  logic                 d0_neg [LANES];

  logic                 st_valid [DIV_STEPS+1];
  logic                 st_pt    [DIV_STEPS+1];
  logic [HW-1:0]        st_md    [DIV_STEPS+1];
  lane_t                st_lane  [DIV_STEPS+1][LANES];

  logic                 hw_neg;
  logic [HW-1:0]        hw_mag;
  logic [OUT_W-1:0]     res [LANES];
  logic                 lane_sat [LANES];
  logic                 any_sat;

  assign en = !out_ch.valid || out_ch.ready;

  assign hw_neg = hom.h[ROWS-1][HW-1];
  assign hw_mag = hw_neg ? HW'(-$signed(hom.h[ROWS-1])) : hom.h[ROWS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_valid <= 1'b0;
    end else if (en) begin
      d0_valid <= hom.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_pt <= (hom.kind == K_PIXEL) && (hom.h[ROWS-1] != '0);
      d0_md <= hw_mag;
      for (int i = 0; i < LANES; i++) begin
        d0_mn[i]  <= hom.h[i][HW-1] ? HW'(-$signed(hom.h[i])) : hom.h[i];
        d0_neg[i] <= hom.h[i][HW-1] ^ hw_neg;
      end
    end
  end

  // quotient needs more than 32 bits when |num| >= |w| * 2^16
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (en) begin
      st_valid[0] <= d0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_pt[0] <= d0_pt;
      st_md[0] <= d0_md;
      for (int i = 0; i < LANES; i++) begin
        st_lane[0][i].big <= {{FRAC_SHIFT{1'b0}}, d0_mn[i]} >= {d0_md, {FRAC_SHIFT{1'b0}}};
        st_lane[0][i].rem <= REM_W'(d0_mn[i][HW-1:FRAC_SHIFT]);
        st_lane[0][i].low <= {d0_mn[i][FRAC_SHIFT-1:0], {(DIV_STEPS-FRAC_SHIFT){1'b0}}};
        st_lane[0][i].q   <= '0;
        st_lane[0][i].neg <= d0_neg[i];
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    lane_t            nxt [LANES];
    logic [REM_W-1:0] rs  [LANES];

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        rs[i]  = {st_lane[k][i].rem[REM_W-2:0], st_lane[k][i].low[DIV_STEPS-1]};
        nxt[i] = st_lane[k][i];
        nxt[i].low = {st_lane[k][i].low[DIV_STEPS-2:0], 1'b0};
        if (rs[i] >= {1'b0, st_md[k]}) begin
          nxt[i].rem = rs[i] - {1'b0, st_md[k]};
          nxt[i].q   = {st_lane[k][i].q[DIV_STEPS-2:0], 1'b1};
        end else begin
          nxt[i].rem = rs[i];
          nxt[i].q   = {st_lane[k][i].q[DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (en) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_pt[k+1] <= st_pt[k];
        st_md[k+1] <= st_md[k];
        for (int i = 0; i < LANES; i++) begin
          st_lane[k+1][i] <= nxt[i];
        end
      end
    end
  end

  always_comb begin
    logic [OUT_W:0]   limit;
    logic [OUT_W-1:0] mag;
    limit   = '0;
    mag     = '0;
    any_sat = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      limit = st_lane[DIV_STEPS][i].neg ? ((OUT_W+1)'(1) << (OUT_W-1))
                                        : ((OUT_W+1)'(1) << (OUT_W-1)) - 1'b1;
      lane_sat[i] = st_lane[DIV_STEPS][i].big ||
                    ({1'b0, st_lane[DIV_STEPS][i].q} > limit);
      mag    = lane_sat[i] ? limit[OUT_W-1:0] : st_lane[DIV_STEPS][i].q;
      res[i] = st_lane[DIV_STEPS][i].neg ? -mag : mag;
      any_sat = any_sat | lane_sat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= st_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.point_valid <= st_pt[DIV_STEPS];
      out_ch.coord_x     <= st_pt[DIV_STEPS] ? res[0] : '0;
      out_ch.coord_y     <= st_pt[DIV_STEPS] ? res[1] : '0;
      out_ch.coord_z     <= st_pt[DIV_STEPS] ? res[2] : '0;
      out_ch.saturated   <= st_pt[DIV_STEPS] && any_sat;
    end
  end
endmodule

// File: hdl/phtt_checker.sv
// port-level checks for the phase-to-point triangulator
module phtt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          point_valid,
  input logic [phtt_pkg::OUT_W-1:0]    coord_x,
  input logic [phtt_pkg::OUT_W-1:0]    coord_y,
  input logic [phtt_pkg::OUT_W-1:0]    coord_z,
  input logic                          saturated
);
  import phtt_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("point item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(coord_x) && $stable(coord_y) && $stable(coord_z))
    else $error("point item changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> coord_x == '0 && coord_y == '0 && coord_z == '0
                                  && !saturated)
    else $error("invalid point carries data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("point item after reset");
endmodule

bind phase_to_point_triangulator_top phtt_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .point_valid (out_ch.point_valid),
  .coord_x     (out_ch.coord_x),
  .coord_y     (out_ch.coord_y),
  .coord_z     (out_ch.coord_z),
  .saturated   (out_ch.saturated)
);
